>>> rtl/fswm_pkg.sv
// shared types, widths and codes for the free space watermark monitor
package fswm_pkg;

  // field widths
  localparam int unsigned BLOCK_COUNT_W = 36;
  localparam int unsigned SIZE_W        = 21;
  localparam int unsigned PROD_W        = BLOCK_COUNT_W + SIZE_W;
  localparam int unsigned BYTES_W       = 56;
  localparam int unsigned TOTAL_W       = 62;
  localparam int unsigned KB_W          = 52;
  localparam int unsigned OUT_KB_W      = 31;
  localparam int unsigned PERIOD_W      = 4;
  localparam int unsigned KB_SHIFT      = 10;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = KB_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FREE_KB     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HWM_FREE_KB     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REMINDER_PERIOD = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 4'd12;

  // default allocation unit when both sizes are zero
  localparam int unsigned DEFAULT_BLOCK_SIZE_DEF = 4096;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // event codes of a result item
  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_BECAME_SHORT = 2'd1,
    EV_BECAME_OK    = 2'd2,
    EV_REMINDER     = 2'd3
  } space_event_e;

  // configuration registers
  typedef struct packed {
    logic [KB_W-1:0]     min_free_kb;
    logic [KB_W-1:0]     hwm_free_kb;
    logic [PERIOD_W-1:0] reminder_period;
  } fswm_cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic               counted;
    logic               last;
  } fswm_item_t;

endpackage

>>> rtl/fswm_front.sv
// front end: takes samples, multiplies out free bytes and classifies them
module fswm_front import fswm_pkg::*; #(
  parameter int unsigned DEFAULT_BLOCK_SIZE = DEFAULT_BLOCK_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [BLOCK_COUNT_W-1:0] block_count_i,
  input  logic [SIZE_W-1:0]        frag_size_i,
  input  logic [SIZE_W-1:0]        block_size_i,
  input  logic                     stat_ok_i,
  input  logic                     last_in_scan_i,
  input  logic [KB_W-1:0]          min_free_kb_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output fswm_item_t               q_item_o
);

  logic              valid_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              ok_q;
  logic              last_q;
  logic [SIZE_W-1:0] unit;
  logic              accept;
  logic [BYTES_W-1:0] bytes;
  logic [TOTAL_W-1:0] threshold;

  // allocation unit selection and product
  always_comb begin
    if (frag_size_i != '0) begin
      unit = frag_size_i;
    end else if (block_size_i != '0) begin
      unit = block_size_i;
    end else begin
      unit = SIZE_W'(DEFAULT_BLOCK_SIZE);
    end
    prod_d = PROD_W'(block_count_i) * PROD_W'(unit);
  end

  // handshake of the multiply stage
  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (q_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
      ok_q   <= stat_ok_i;
      last_q <= last_in_scan_i;
    end
  end

  // saturate free bytes and compare against the minimum
  assign bytes     = prod_q[PROD_W-1] ? {BYTES_W{1'b1}} : prod_q[BYTES_W-1:0];
  assign threshold = {min_free_kb_i, {KB_SHIFT{1'b0}}};

  always_comb begin
    q_item_o.bytes   = bytes;
    q_item_o.counted = ok_q && ({{(TOTAL_W-BYTES_W){1'b0}}, bytes} >= threshold);
    q_item_o.last    = last_q;
  end

endmodule

>>> rtl/fswm_queue.sv
// small queue that decouples the front end from the back end
module fswm_queue import fswm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fswm_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output fswm_item_t item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  fswm_item_t        entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/fswm_back.sv
// back end: accumulates counted samples and closes each scan with a result
module fswm_back import fswm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fswm_cfg_t           cfg_i,
  input  logic                q_empty_i,
  input  fswm_item_t          q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_KB_W-1:0] max_free_kb_o,
  output logic [OUT_KB_W-1:0] total_free_kb_o,
  output logic                short_of_space_o,
  output logic [1:0]          space_event_o
);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // kilobytes saturated to the output width
  function automatic logic [OUT_KB_W-1:0] kb_sat(input logic [KB_W-1:0] kb);
    logic high;
    high = |kb[KB_W-1:OUT_KB_W];
    return high ? {OUT_KB_W{1'b1}} : kb[OUT_KB_W-1:0];
  endfunction

  logic [BYTES_W-1:0] largest_q, largest_new;
  logic [TOTAL_W-1:0] total_q, total_new;
  logic [TOTAL_W:0]   sum;

  logic               close_valid_q;
  logic [BYTES_W-1:0] close_largest_q;
  logic [TOTAL_W-1:0] close_total_q;
  logic               close_ready;
  logic               fire;

  logic                space_short_q, space_short_d;
  logic [PERIOD_W-1:0] reminder_count_q, reminder_count_d;
  logic                first_done_q;
  space_event_e        event_d;

  logic [KB_W-1:0] max_kb;
  logic [KB_W-1:0] total_kb;
  logic            now_short;

  logic                out_valid_q;
  logic [OUT_KB_W-1:0] out_max_q;
  logic [OUT_KB_W-1:0] out_total_q;
  logic                out_short_q;
  space_event_e        out_event_q;

  // handshakes between the two back stages
  assign close_ready = !out_valid_q || !out_stall_i;
  assign fire        = close_valid_q && close_ready;
  assign q_pop_o     = !q_empty_i && (!close_valid_q || close_ready);

  // accumulate largest and saturating total
  always_comb begin
    sum         = {1'b0, total_q} + {{(TOTAL_W-BYTES_W+1){1'b0}}, q_item_i.bytes};
    largest_new = largest_q;
    total_new   = total_q;
    if (q_item_i.counted) begin
      total_new = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (q_item_i.bytes > largest_q) begin
        largest_new = q_item_i.bytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q     <= '0;
      total_q       <= '0;
      close_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        if (q_item_i.last) begin
          largest_q <= '0;
          total_q   <= '0;
        end else begin
          largest_q <= largest_new;
          total_q   <= total_new;
        end
      end
      if (q_pop_o && q_item_i.last) begin
        close_valid_q <= 1'b1;
      end else if (close_ready) begin
        close_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.last) begin
      close_largest_q <= largest_new;
      close_total_q   <= total_new;
    end
  end

  // hysteresis decision and event code
  assign max_kb   = KB_W'(close_largest_q[BYTES_W-1:KB_SHIFT]);
  assign total_kb = close_total_q[TOTAL_W-1:KB_SHIFT];

  always_comb begin
    now_short        = max_kb < (space_short_q ? cfg_i.hwm_free_kb : cfg_i.min_free_kb);
    space_short_d    = space_short_q;
    reminder_count_d = reminder_count_q;
    event_d          = EV_NONE;
    if (!first_done_q) begin
      space_short_d = max_kb < cfg_i.min_free_kb;
    end else begin
      if (now_short != space_short_q) begin
        event_d       = now_short ? EV_BECAME_SHORT : EV_BECAME_OK;
        space_short_d = now_short;
      end else if (space_short_q && reminder_count_q == '0) begin
        event_d = EV_REMINDER;
      end
      reminder_count_d = (reminder_count_q != '0) ? reminder_count_q - 1'b1
                                                  : cfg_i.reminder_period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_short_q    <= 1'b0;
      reminder_count_q <= '0;
      first_done_q     <= 1'b0;
    end else if (fire) begin
      space_short_q    <= space_short_d;
      reminder_count_q <= reminder_count_d;
      first_done_q     <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_max_q   <= kb_sat(max_kb);
      out_total_q <= kb_sat(total_kb);
      out_short_q <= space_short_d;
      out_event_q <= event_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign max_free_kb_o    = out_max_q;
  assign total_free_kb_o  = out_total_q;
  assign short_of_space_o = out_short_q;
  assign space_event_o    = out_event_q;

endmodule

>>> rtl/free_space_watermark_monitor.sv
// top level of the free space watermark monitor
// Takes one filesystem sample per item and sustains one item per clock cycle when
// no stall holds the flow: the front end multiplies block count by allocation unit
// in one 36x21 bit multiplier stage, a two-entry queue separates it from the back
// end, and the back end folds one sample per cycle, unless the scan close is held,
// into the largest and saturating total with a single 62-bit adder. The item marked
// last in scan yields one result item that passes the multiply stage, the queue,
// the scan close register with the hysteresis decision behind it and the result
// register; other items yield none. Configuration writes are taken every cycle and
// are meant to happen while the block is idle.
module free_space_watermark_monitor import fswm_pkg::*; #(
  parameter int unsigned DEFAULT_BLOCK_SIZE = DEFAULT_BLOCK_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [BLOCK_COUNT_W-1:0] block_count_i,
  input  logic [SIZE_W-1:0]        frag_size_i,
  input  logic [SIZE_W-1:0]        block_size_i,
  input  logic                     stat_ok_i,
  input  logic                     last_in_scan_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [OUT_KB_W-1:0]      max_free_kb_o,
  output logic [OUT_KB_W-1:0]      total_free_kb_o,
  output logic                     short_of_space_o,
  output logic [1:0]               space_event_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  fswm_cfg_t  cfg_q;
  logic       q_push, q_full, q_pop, q_empty;
  fswm_item_t q_wr_item, q_rd_item;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_free_kb     <= '0;
      cfg_q.hwm_free_kb     <= '0;
      cfg_q.reminder_period <= PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_FREE_KB:     cfg_q.min_free_kb     <= cfg_data_i;
        CFG_HWM_FREE_KB:     cfg_q.hwm_free_kb     <= cfg_data_i;
        CFG_REMINDER_PERIOD: cfg_q.reminder_period <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  fswm_front #(
    .DEFAULT_BLOCK_SIZE(DEFAULT_BLOCK_SIZE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .block_count_i  (block_count_i),
    .frag_size_i    (frag_size_i),
    .block_size_i   (block_size_i),
    .stat_ok_i      (stat_ok_i),
    .last_in_scan_i (last_in_scan_i),
    .min_free_kb_i  (cfg_q.min_free_kb),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_wr_item)
  );

  // queue
  fswm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  // back end
  fswm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_item_i         (q_rd_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .max_free_kb_o    (max_free_kb_o),
    .total_free_kb_o  (total_free_kb_o),
    .short_of_space_o (short_of_space_o),
    .space_event_o    (space_event_o)
  );

  // assertions
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("item pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("item popped from an empty queue");

  a_short_event_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (space_event_o == EV_BECAME_SHORT || space_event_o == EV_REMINDER)
    |-> short_of_space_o)
    else $error("short event without short flag");

  a_ok_event_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && space_event_o == EV_BECAME_OK |-> !short_of_space_o)
    else $error("sufficient event with short flag");

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the free space watermark monitor
module tb_top;
  import fswm_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned PRINT_LIMIT  = 40;

  // one filesystem sample as it enters the block
  typedef struct packed {
    logic [BLOCK_COUNT_W-1:0] count;
    logic [SIZE_W-1:0]        frag;
    logic [SIZE_W-1:0]        bsz;
    logic                     ok;
    logic                     last;
  } fs_sample_t;

  // one end-of-scan report as it leaves the block
  typedef struct packed {
    logic [OUT_KB_W-1:0] max_kb;
    logic [OUT_KB_W-1:0] total_kb;
    logic                short_flag;
    space_event_e        ev;
  } space_report_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_REGS
  } row_kind_e;

  // directed stimulus row: a sample, or a full register load
  typedef struct {
    row_kind_e       kind;
    fs_sample_t      smp;
    bit              typed;
    space_report_t   want;
    logic [KB_W-1:0] min_kb;
    logic [KB_W-1:0] hwm_kb;
    logic [PERIOD_W-1:0] per;
  } plan_row_t;

  // block ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [BLOCK_COUNT_W-1:0] block_count_i;
  logic [SIZE_W-1:0]        frag_size_i;
  logic [SIZE_W-1:0]        block_size_i;
  logic                     stat_ok_i;
  logic                     last_in_scan_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [OUT_KB_W-1:0]      max_free_kb_o;
  logic [OUT_KB_W-1:0]      total_free_kb_o;
  logic                     short_of_space_o;
  logic [1:0]               space_event_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_INDEX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  // predictor state and its copy of the registers
  logic [BYTES_W-1:0]  largest_b  = '0;
  logic [TOTAL_W-1:0]  total_b    = '0;
  logic                short_q    = 1'b0;
  logic [PERIOD_W-1:0] remind_cnt = '0;
  logic                seen_scan  = 1'b0;
  logic [KB_W-1:0]     min_kb_q   = '0;
  logic [KB_W-1:0]     hwm_kb_q   = '0;
  logic [PERIOD_W-1:0] period_q   = PERIOD_RESET;

  space_report_t pending_reports [$];
  plan_row_t     plan [$];
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;
  int unsigned   calm_items = 0;
  int unsigned   stall_hold = 0;
  logic          stall_level = 1'b0;

  free_space_watermark_monitor dut (.*);

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // bytes to kilobytes, saturated to the output width
  function automatic logic [OUT_KB_W-1:0] sat_kb(input logic [TOTAL_W-1:0] bytes);
    logic [TOTAL_W-KB_SHIFT-1:0] kb;
    kb = bytes[TOTAL_W-1:KB_SHIFT];
    return (kb > {OUT_KB_W{1'b1}}) ? '1 : kb[OUT_KB_W-1:0];
  endfunction

  // folds one sample into the scan; returns 1 with the report when the scan closes
  function automatic bit fold_sample(input fs_sample_t s, output space_report_t r);
    logic [SIZE_W-1:0]           unit;
    logic [PROD_W-1:0]           prod;
    logic [BYTES_W-1:0]          bytes;
    logic [TOTAL_W:0]            sum;
    logic [BYTES_W-KB_SHIFT-1:0] big_kb;
    logic                        now_short;
    r = '0;
    // qualify and accumulate
    if (s.ok) begin
      unit = (s.frag != 0) ? s.frag :
             (s.bsz != 0) ? s.bsz : SIZE_W'(DEFAULT_BLOCK_SIZE_DEF);
      prod = PROD_W'(s.count) * PROD_W'(unit);
      bytes = (prod > PROD_W'({BYTES_W{1'b1}})) ? '1 : prod[BYTES_W-1:0];
      if (TOTAL_W'(bytes) >= {min_kb_q, {KB_SHIFT{1'b0}}}) begin
        sum = {1'b0, total_b} + (TOTAL_W + 1)'(bytes);
        total_b = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        if (bytes > largest_b) largest_b = bytes;
      end
    end
    if (!s.last) return 1'b0;
    // close the scan: hysteresis and event
    big_kb = largest_b[BYTES_W-1:KB_SHIFT];
    r.ev = EV_NONE;
    if (!seen_scan) begin
      short_q = KB_W'(big_kb) < min_kb_q;
      seen_scan = 1'b1;
    end else begin
      now_short = KB_W'(big_kb) < (short_q ? hwm_kb_q : min_kb_q);
      if (now_short != short_q) begin
        r.ev = now_short ? EV_BECAME_SHORT : EV_BECAME_OK;
        short_q = now_short;
      end else if (short_q && remind_cnt == 0) begin
        r.ev = EV_REMINDER;
      end
      remind_cnt = (remind_cnt != 0) ? remind_cnt - 1'b1 : period_q;
    end
    r.max_kb = sat_kb(TOTAL_W'(largest_b));
    r.total_kb = sat_kb(total_b);
    r.short_flag = short_q;
    largest_b = '0;
    total_b = '0;
    return 1'b1;
  endfunction

  // input gap: mostly none or short, a few long, with calm stretches
  function automatic int unsigned pick_pause();
    int unsigned pick;
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm_items = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random sample; heavy scans lean on the largest products
  function automatic fs_sample_t rand_sample(input bit last, input bit heavy);
    fs_sample_t  s;
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    s.count = BLOCK_COUNT_W'($urandom_range(0, 9000));
    s.frag = SIZE_W'(1024);
    s.bsz = SIZE_W'($urandom);
    if (heavy && pick < 85) begin
      s.count = '1;
      s.frag = (pick < 40) ? '1 : SIZE_W'(1 << 20);
    end else if (pick < 60) begin
      // kilobyte units, close to the thresholds
    end else if (pick < 72) begin
      s.frag = '0;
      if (pick < 66) begin
        s.bsz = SIZE_W'(1024);
      end else begin
        s.bsz = '0;
        s.count = BLOCK_COUNT_W'($urandom_range(0, 2250));
      end
    end else if (pick < 90) begin
      s.count = raw[BLOCK_COUNT_W-1:0];
      s.frag = (pick < 78) ? '0 : SIZE_W'($urandom_range(0, 1 << 20));
      s.bsz = SIZE_W'($urandom_range(0, 1 << 20));
    end else begin
      s.count = pick[0] ? '1 : '0;
      case ($urandom_range(0, 3))
        0: s.frag = '0;
        1: s.frag = SIZE_W'(1);
        2: s.frag = SIZE_W'(1 << 20);
        default: s.frag = '1;
      endcase
    end
    s.ok = ($urandom_range(0, 99) < 88);
    s.last = last;
    return s;
  endfunction

  function automatic void sample_row(input logic [BLOCK_COUNT_W-1:0] c,
                                     input logic [SIZE_W-1:0] f, input logic [SIZE_W-1:0] b,
                                     input logic ok, input logic last, input bit typed,
                                     input logic [OUT_KB_W-1:0] mx,
                                     input logic [OUT_KB_W-1:0] tot,
                                     input logic sh, input space_event_e ev);
    plan_row_t row;
    row.kind = ROW_SAMPLE;
    row.smp = '{count: c, frag: f, bsz: b, ok: ok, last: last};
    row.typed = typed;
    row.want.max_kb = mx;
    row.want.total_kb = tot;
    row.want.short_flag = sh;
    row.want.ev = ev;
    row.min_kb = '0;
    row.hwm_kb = '0;
    row.per = '0;
    plan.push_back(row);
  endfunction

  function automatic void regs_row(input logic [KB_W-1:0] min_kb,
                                   input logic [KB_W-1:0] hwm_kb,
                                   input logic [PERIOD_W-1:0] per);
    plan_row_t row;
    row.kind = ROW_REGS;
    row.smp = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.min_kb = min_kb;
    row.hwm_kb = hwm_kb;
    row.per = per;
    plan.push_back(row);
  endfunction

  // hands one sample over and records what it should produce
  task automatic send_sample(input fs_sample_t s, input bit typed,
                             input space_report_t typed_want);
    int unsigned   gap;
    space_report_t r;
    gap = pick_pause();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_count_i <= s.count;
    frag_size_i <= s.frag;
    block_size_i <= s.bsz;
    stat_ok_i <= s.ok;
    last_in_scan_i <= s.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (fold_sample(s, r)) pending_reports.push_back(typed ? typed_want : r);
  endtask

  // wait until every report is out and the pipeline has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers back to back
  task automatic load_regs(input logic [KB_W-1:0] min_kb, input logic [KB_W-1:0] hwm_kb,
                           input logic [PERIOD_W-1:0] per);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0]  val [3];
    logic [63:0]            junk;
    int                     i;
    junk = {$urandom, $urandom};
    idx[0] = CFG_MIN_FREE_KB;
    idx[1] = CFG_HWM_FREE_KB;
    idx[2] = CFG_REMINDER_PERIOD;
    val[0] = min_kb;
    val[1] = hwm_kb;
    // upper bits of the period write are don't-care
    val[2] = {junk[CFG_DATA_W-PERIOD_W-1:0], per};
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    min_kb_q = min_kb;
    hwm_kb_q = hwm_kb;
    period_q = per;
  endtask

  // output backpressure: short bursts, a few long stalls, calm stretches
  always @(posedge clk_i) begin : stall_gen
    int unsigned pick;
    if (stall_hold == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        stall_level = 1'b0;
        stall_hold = $urandom_range(1, 6);
      end else if (pick < 75) begin
        stall_level = 1'b1;
        stall_hold = $urandom_range(1, 3);
      end else if (pick < 85) begin
        stall_level = 1'b1;
        stall_hold = $urandom_range(10, 40);
      end else begin
        stall_level = 1'b0;
        stall_hold = $urandom_range(30, 150);
      end
    end
    stall_hold = stall_hold - 1;
    out_stall_i <= stall_level;
  end

  // compare each accepted report with the oldest pending one
  always @(posedge clk_i) begin : watch_reports
    space_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report item with none pending");
      end else begin
        want = pending_reports.pop_front();
        if (max_free_kb_o !== want.max_kb)
          report_mismatch($sformatf("max_free_kb got %0h want %0h",
                                    max_free_kb_o, want.max_kb));
        if (total_free_kb_o !== want.total_kb)
          report_mismatch($sformatf("total_free_kb got %0h want %0h",
                                    total_free_kb_o, want.total_kb));
        if (short_of_space_o !== want.short_flag)
          report_mismatch($sformatf("short_of_space got %0b want %0b",
                                    short_of_space_o, want.short_flag));
        if (space_event_o !== want.ev)
          report_mismatch($sformatf("space_event got %0d want %0d",
                                    space_event_o, want.ev));
      end
    end
  end

  initial begin
    int unsigned         ph;
    int unsigned         sent;
    int unsigned         len;
    int unsigned         k;
    bit                  heavy;
    logic [63:0]         raw;
    logic [KB_W-1:0]     min_kb;
    logic [KB_W-1:0]     hwm_kb;
    logic [PERIOD_W-1:0] per;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    block_count_i = '0;
    frag_size_i = '0;
    block_size_i = '0;
    stat_ok_i = 1'b0;
    last_in_scan_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MIN_FREE_KB;
    cfg_data_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; frag_size 1024 makes the block count read as kilobytes
    // first scan at reset settings, also an empty-looking scan
    sample_row(36'd0, 21'd0, 21'd0, 1, 1, 1, 31'd0, 31'd0, 0, EV_NONE);
    regs_row(52'd1000, 52'd4000, 4'd2);
    // oversized product saturates, then a too-small sample is dropped
    sample_row(36'hF_FFFF_FFFF, 21'h1F_FFFF, 21'd0, 1, 0, 0, '0, '0, 0, EV_NONE);
    sample_row(36'd500, 21'd1024, 21'd0, 1, 1, 1, 31'h7fff_ffff, 31'h7fff_ffff, 0,
               EV_NONE);
    // nothing counted: becomes short
    sample_row(36'd500, 21'd1024, 21'd0, 1, 1, 1, 31'd0, 31'd0, 1, EV_BECAME_SHORT);
    // block size fallback, still below the high watermark
    sample_row(36'd2000, 21'd0, 21'd1024, 1, 1, 1, 31'd2000, 31'd2000, 1, EV_NONE);
    // default unit fallback, reminder due
    sample_row(36'd500, 21'd0, 21'd0, 1, 1, 1, 31'd2000, 31'd2000, 1, EV_REMINDER);
    // failed query is skipped
    sample_row(36'd100000, 21'd1024, 21'd0, 0, 0, 0, '0, '0, 0, EV_NONE);
    sample_row(36'd3000, 21'd1024, 21'd0, 1, 0, 0, '0, '0, 0, EV_NONE);
    sample_row(36'd2000, 21'd1024, 21'd0, 1, 1, 1, 31'd3000, 31'd5000, 1, EV_NONE);
    // exactly at the high watermark leaves the short state
    sample_row(36'd4000, 21'd1024, 21'd0, 1, 1, 1, 31'd4000, 31'd4000, 0, EV_BECAME_OK);
    // exactly at the minimum counts and stays sufficient
    sample_row(36'd1000, 21'd1024, 21'd0, 1, 1, 1, 31'd1000, 31'd1000, 0, EV_NONE);
    sample_row(36'd999, 21'd1024, 21'd0, 1, 1, 1, 31'd0, 31'd0, 1, EV_BECAME_SHORT);
    // zero reminder period: reminder on every scan once the count runs out
    regs_row(52'd1000, 52'd4000, 4'd0);
    sample_row(36'd0, 21'd1024, 21'd0, 1, 1, 0, '0, '0, 0, EV_NONE);
    sample_row(36'd0, 21'd1024, 21'd0, 1, 1, 1, 31'd0, 31'd0, 1, EV_REMINDER);
    sample_row(36'd0, 21'd1024, 21'd0, 1, 1, 1, 31'd0, 31'd0, 1, EV_REMINDER);
    // largest in-range product
    sample_row(36'hF_FFFF_FFFF, 21'h10_0000, 21'd0, 1, 1, 1, 31'h7fff_ffff,
               31'h7fff_ffff, 0, EV_BECAME_OK);
    sample_row(36'd1, 21'd0, 21'h1F_FFFF, 1, 0, 0, '0, '0, 0, EV_NONE);
    sample_row(36'd3, 21'd0, 21'h10_0000, 1, 1, 0, '0, '0, 0, EV_NONE);
    // closing sample that failed its query: empty scan
    sample_row(36'hF_FFFF_FFFF, 21'd1024, 21'd0, 0, 1, 1, 31'd0, 31'd0, 1,
               EV_BECAME_SHORT);
    sample_row(36'd5, 21'd1, 21'd0, 1, 0, 0, '0, '0, 0, EV_NONE);
    sample_row(36'h5_5555_5555, 21'h0A_AAAA, 21'h15_5555, 1, 1, 0, '0, '0, 0, EV_NONE);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGS) begin
        settle();
        load_regs(plan[i].min_kb, plan[i].hwm_kb, plan[i].per);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      raw = {$urandom, $urandom};
      case (ph)
        0: begin
          min_kb = '0;
          hwm_kb = '0;
          per = 4'd1;
        end
        1: begin
          min_kb = '1;
          hwm_kb = '1;
          per = '1;
        end
        2: begin
          min_kb = raw[KB_W-1:0];
          hwm_kb = KB_W'({$urandom, $urandom});
          per = PERIOD_W'($urandom);
        end
        3: begin
          // once short, never leaves
          min_kb = KB_W'(2000);
          hwm_kb = '1;
          per = PERIOD_W'($urandom_range(0, 3));
        end
        default: begin
          min_kb = KB_W'($urandom_range(0, 6000));
          hwm_kb = ($urandom_range(0, 3) != 0) ? min_kb + KB_W'($urandom_range(0, 6000))
                                               : KB_W'($urandom_range(0, 6000));
          per = PERIOD_W'($urandom_range(0, 15));
        end
      endcase
      settle();
      load_regs(min_kb, hwm_kb, per);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        heavy = ($urandom_range(0, 99) < 5);
        len = heavy ? $urandom_range(70, 120) : $urandom_range(1, 6);
        for (k = 0; k < len; k++)
          send_sample(rand_sample(k == len - 1, heavy), 1'b0, '0);
        sent += len;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
